>>> design/dwcg_pkg.sv
// ----------------------------------------------------------------------------
// Display window command generator package
// Shared constants, codes, job descriptor type and small helper functions.
// ----------------------------------------------------------------------------
package dwcg_pkg;

  localparam int MAX_SIDE    = 1024;
  localparam int SIDE_W      = $clog2(MAX_SIDE + 1);
  localparam int COORD_W     = $clog2(MAX_SIDE);
  localparam int AREA_W      = 21;
  localparam int WORD_W      = 16;
  localparam int POS_W       = 16;
  localparam int EXT_W       = POS_W + 2;
  localparam int STEP_W      = 3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int PEND_W      = QCOUNT_W + 1;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CFG_INDEX_W-1:0] REG_ORIENTATION      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLOR_ORDER_BGR  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NATIVE_WIDTH     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NATIVE_HEIGHT    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_READBACK_PRESENT = 3'd4;

  localparam logic [1:0] OP_WRITE_PIXEL = 2'd0;
  localparam logic [1:0] OP_READ_PIXEL  = 2'd1;
  localparam logic [1:0] OP_SET_WINDOW  = 2'd2;
  localparam logic [1:0] OP_ORIENT      = 2'd3;

  localparam logic [2:0] KIND_CMD    = 3'd0;
  localparam logic [2:0] KIND_BYTE   = 3'd1;
  localparam logic [2:0] KIND_WORD   = 3'd2;
  localparam logic [2:0] KIND_READ   = 3'd3;
  localparam logic [2:0] KIND_STATUS = 3'd4;

  localparam logic [7:0] CMD_COLUMN   = 8'h2A;
  localparam logic [7:0] CMD_ROW      = 8'h2B;
  localparam logic [7:0] CMD_MEMWRITE = 8'h2C;
  localparam logic [7:0] CMD_ACCESS   = 8'h36;

  typedef enum logic [4:0] {
    JOB_STATUS = 5'b00001,
    JOB_ORIENT = 5'b00010,
    JOB_WINDOW = 5'b00100,
    JOB_WRITE  = 5'b01000,
    JOB_READ   = 5'b10000
  } job_kind_t;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    job_kind_t          kind;
    coord_t             x0;
    coord_t             x1;
    coord_t             y0;
    coord_t             y1;
    logic [WORD_W-1:0]  data;
    logic [AREA_W-1:0]  area;
  } job_desc_t;

  typedef struct packed {
    logic my;
    logic mx;
    logic mv;
  } orient_bits_t;

  function automatic orient_bits_t orient_decode(input logic [2:0] code);
    orient_bits_t b;
    case (code)
      3'd0:    b = '{my: 1'b1, mx: 1'b0, mv: 1'b0};
      3'd1:    b = '{my: 1'b1, mx: 1'b1, mv: 1'b1};
      3'd2:    b = '{my: 1'b0, mx: 1'b1, mv: 1'b0};
      3'd3:    b = '{my: 1'b0, mx: 1'b0, mv: 1'b1};
      3'd4:    b = '{my: 1'b1, mx: 1'b1, mv: 1'b0};
      3'd5:    b = '{my: 1'b1, mx: 1'b0, mv: 1'b1};
      3'd6:    b = '{my: 1'b0, mx: 1'b0, mv: 1'b0};
      default: b = '{my: 1'b0, mx: 1'b1, mv: 1'b1};
    endcase
    return b;
  endfunction

  // Panel sizes of zero count as one, and sizes above the limit are capped.
  function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) begin
      return SIDE_W'(1);
    end else if (32'(v) > 32'(MAX_SIDE)) begin
      return SIDE_W'(MAX_SIDE);
    end else begin
      return SIDE_W'(v);
    end
  endfunction

  function automatic coord_t clamp_coord(input logic signed [EXT_W-1:0] v,
                                         input coord_t hi);
    if (v[EXT_W-1]) begin
      return '0;
    end else if (v > $signed({{(EXT_W-COORD_W){1'b0}}, hi})) begin
      return hi;
    end else begin
      return v[COORD_W-1:0];
    end
  endfunction

endpackage

>>> design/display_window_command_generator.sv
// ----------------------------------------------------------------------------
// Display window command generator
// Turns pixel, window and orientation requests into the command and data word
// stream of a serial TFT controller.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request yields
// one word per clock cycle on strobe: one status word for a rejected pixel,
// three for an orientation request, seven for a window and eight for a pixel
// write or read, as set by the word sequencer. On its way out a request
// passes the bounds/clamp register, which loads at the accepting edge, then
// the area multiply, which writes the job queue, and then the output
// register, which loads its first word once the jobs ahead of it have gone
// out. A four-entry job queue lets requests arrive back to back
// while earlier words still go out; busy rises only when the queue and the
// front stage together hold four jobs. Words cannot be held off: each is valid
// for exactly the one cycle that strobe is high. Configuration writes take
// effect at once and must be made only while no request is in progress.
// ----------------------------------------------------------------------------
module display_window_command_generator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            operation,
  input  logic signed [dwcg_pkg::POS_W-1:0]     pos_x,
  input  logic signed [dwcg_pkg::POS_W-1:0]     pos_y,
  input  logic [dwcg_pkg::WORD_W-1:0]           win_width,
  input  logic [dwcg_pkg::WORD_W-1:0]           win_height,
  input  logic [dwcg_pkg::WORD_W-1:0]           pixel_color,
  input  logic                                  cfg_write,
  input  logic [dwcg_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [dwcg_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                  strobe,
  output logic [2:0]                            word_kind,
  output logic [dwcg_pkg::WORD_W-1:0]           word_value,
  output logic                                  on_screen,
  output logic [dwcg_pkg::AREA_W-1:0]           clipped_area,
  output logic                                  last_word
);

  logic                          push;
  dwcg_pkg::job_desc_t           push_desc;
  logic                          pop;
  dwcg_pkg::job_desc_t           head;
  logic [dwcg_pkg::QCOUNT_W-1:0] queue_count;

  dwcg_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .win_width   (win_width),
    .win_height  (win_height),
    .pixel_color (pixel_color),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .push_desc   (push_desc),
    .queue_count (queue_count)
  );

  dwcg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .count     (queue_count)
  );

  dwcg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .queue_count  (queue_count),
    .pop          (pop),
    .strobe       (strobe),
    .word_kind    (word_kind),
    .word_value   (word_value),
    .on_screen    (on_screen),
    .clipped_area (clipped_area),
    .last_word    (last_word)
  );

endmodule

>>> design/dwcg_queue.sv
// ----------------------------------------------------------------------------
// Job queue
// Short first-in first-out buffer of job descriptors between front and back.
// ----------------------------------------------------------------------------
module dwcg_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  dwcg_pkg::job_desc_t           push_desc,
  input  logic                          pop,
  output dwcg_pkg::job_desc_t           head,
  output logic [dwcg_pkg::QCOUNT_W-1:0] count
);

  dwcg_pkg::job_desc_t               entries [dwcg_pkg::QUEUE_DEPTH];
  logic [dwcg_pkg::QPTR_W-1:0]       wr_ptr;
  logic [dwcg_pkg::QPTR_W-1:0]       rd_ptr;

  function automatic logic [dwcg_pkg::QPTR_W-1:0] ptr_inc(
      input logic [dwcg_pkg::QPTR_W-1:0] p);
    if (p == dwcg_pkg::QPTR_W'(dwcg_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end else begin
      return p + dwcg_pkg::QPTR_W'(1);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + dwcg_pkg::QCOUNT_W'(1);
      end else if (pop && !push) begin
        count <= count - dwcg_pkg::QCOUNT_W'(1);
      end
    end
  end

  assign head = entries[rd_ptr];

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (count != dwcg_pkg::QCOUNT_W'(dwcg_pkg::QUEUE_DEPTH)))
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("job queue read while empty");

endmodule

>>> design/dwcg_front.sv
// ----------------------------------------------------------------------------
// Request front end
// Holds the configuration registers, accepts requests, checks bounds, clamps
// window ends and computes the clipped area before queueing a job.
// ----------------------------------------------------------------------------
module dwcg_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            operation,
  input  logic signed [dwcg_pkg::POS_W-1:0]     pos_x,
  input  logic signed [dwcg_pkg::POS_W-1:0]     pos_y,
  input  logic [dwcg_pkg::WORD_W-1:0]           win_width,
  input  logic [dwcg_pkg::WORD_W-1:0]           win_height,
  input  logic [dwcg_pkg::WORD_W-1:0]           pixel_color,
  input  logic                                  cfg_write,
  input  logic [dwcg_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [dwcg_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                  push,
  output dwcg_pkg::job_desc_t                   push_desc,
  input  logic [dwcg_pkg::QCOUNT_W-1:0]         queue_count
);

  logic [2:0]                       orientation;
  logic                             color_order_bgr;
  logic [dwcg_pkg::CFG_DATA_W-1:0]  native_width;
  logic [dwcg_pkg::CFG_DATA_W-1:0]  native_height;
  logic                             readback_present;

  dwcg_pkg::orient_bits_t           ob;
  logic [dwcg_pkg::SIDE_W-1:0]      nw;
  logic [dwcg_pkg::SIDE_W-1:0]      nh;
  logic [dwcg_pkg::SIDE_W-1:0]      sw;
  logic [dwcg_pkg::SIDE_W-1:0]      sh;
  logic [dwcg_pkg::SIDE_W-1:0]      sw_dec;
  logic [dwcg_pkg::SIDE_W-1:0]      sh_dec;
  dwcg_pkg::coord_t                 sw_max;
  dwcg_pkg::coord_t                 sh_max;
  logic signed [dwcg_pkg::EXT_W-1:0] x_start;
  logic signed [dwcg_pkg::EXT_W-1:0] y_start;
  logic signed [dwcg_pkg::EXT_W-1:0] x_end;
  logic signed [dwcg_pkg::EXT_W-1:0] y_end;
  logic                             x_in;
  logic                             y_in;
  logic                             on_panel;
  logic                             accept;
  logic [dwcg_pkg::PEND_W-1:0]      pending;
  dwcg_pkg::job_desc_t              s1_next;

  logic                             s1_valid;
  dwcg_pkg::job_desc_t              s1_desc;

  logic [dwcg_pkg::SIDE_W-1:0]      x_span;
  logic [dwcg_pkg::SIDE_W-1:0]      y_span;
  logic [2*dwcg_pkg::SIDE_W-1:0]    product;

  always_ff @(posedge clk) begin
    if (rst) begin
      orientation      <= 3'd0;
      color_order_bgr  <= 1'b1;
      native_width     <= dwcg_pkg::CFG_DATA_W'(240);
      native_height    <= dwcg_pkg::CFG_DATA_W'(320);
      readback_present <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        dwcg_pkg::REG_ORIENTATION:      orientation      <= cfg_data[2:0];
        dwcg_pkg::REG_COLOR_ORDER_BGR:  color_order_bgr  <= cfg_data[0];
        dwcg_pkg::REG_NATIVE_WIDTH:     native_width     <= cfg_data;
        dwcg_pkg::REG_NATIVE_HEIGHT:    native_height    <= cfg_data;
        dwcg_pkg::REG_READBACK_PRESENT: readback_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Space in the queue is reserved at acceptance, so the job in the middle
  // register can always be pushed on the following edge.
  assign pending = {1'b0, queue_count} + {{dwcg_pkg::QCOUNT_W{1'b0}}, s1_valid};
  assign busy    = pending >= dwcg_pkg::PEND_W'(dwcg_pkg::QUEUE_DEPTH);
  assign accept  = start && !busy;

  assign ob     = dwcg_pkg::orient_decode(orientation);
  assign nw     = dwcg_pkg::clamp_side(native_width);
  assign nh     = dwcg_pkg::clamp_side(native_height);
  assign sw     = ob.mv ? nh : nw;
  assign sh     = ob.mv ? nw : nh;
  assign sw_dec = sw - dwcg_pkg::SIDE_W'(1);
  assign sh_dec = sh - dwcg_pkg::SIDE_W'(1);
  assign sw_max = sw_dec[dwcg_pkg::COORD_W-1:0];
  assign sh_max = sh_dec[dwcg_pkg::COORD_W-1:0];

  assign x_start = {{2{pos_x[dwcg_pkg::POS_W-1]}}, pos_x};
  assign y_start = {{2{pos_y[dwcg_pkg::POS_W-1]}}, pos_y};
  assign x_end   = x_start + $signed({2'b00, win_width}) - dwcg_pkg::EXT_W'(1);
  assign y_end   = y_start + $signed({2'b00, win_height}) - dwcg_pkg::EXT_W'(1);

  assign x_in     = !pos_x[dwcg_pkg::POS_W-1] &&
                    (32'(pos_x[dwcg_pkg::POS_W-2:0]) < 32'(sw));
  assign y_in     = !pos_y[dwcg_pkg::POS_W-1] &&
                    (32'(pos_y[dwcg_pkg::POS_W-2:0]) < 32'(sh));
  assign on_panel = x_in && y_in &&
                    !(operation == dwcg_pkg::OP_READ_PIXEL && !readback_present);

  always_comb begin
    s1_next      = '0;
    s1_next.kind = dwcg_pkg::JOB_STATUS;
    case (operation)
      dwcg_pkg::OP_ORIENT: begin
        s1_next.kind = dwcg_pkg::JOB_ORIENT;
        s1_next.data = dwcg_pkg::WORD_W'({ob.my, ob.mx, ob.mv, 1'b0,
                                          color_order_bgr, 3'b000});
      end
      dwcg_pkg::OP_SET_WINDOW: begin
        s1_next.kind = dwcg_pkg::JOB_WINDOW;
        s1_next.x0   = dwcg_pkg::clamp_coord(x_start, sw_max);
        s1_next.x1   = dwcg_pkg::clamp_coord(x_end, sw_max);
        s1_next.y0   = dwcg_pkg::clamp_coord(y_start, sh_max);
        s1_next.y1   = dwcg_pkg::clamp_coord(y_end, sh_max);
      end
      default: begin
        if (on_panel) begin
          s1_next.kind = (operation == dwcg_pkg::OP_READ_PIXEL) ?
                         dwcg_pkg::JOB_READ : dwcg_pkg::JOB_WRITE;
          s1_next.x0   = pos_x[dwcg_pkg::COORD_W-1:0];
          s1_next.x1   = sw_max;
          s1_next.y0   = pos_y[dwcg_pkg::COORD_W-1:0];
          s1_next.y1   = sh_max;
          s1_next.data = pixel_color;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_desc <= s1_next;
    end
  end

  // A clamped end sits at most one below its start, so each span is 0..MAX_SIDE.
  assign x_span  = dwcg_pkg::SIDE_W'(s1_desc.x1) - dwcg_pkg::SIDE_W'(s1_desc.x0) +
                   dwcg_pkg::SIDE_W'(1);
  assign y_span  = dwcg_pkg::SIDE_W'(s1_desc.y1) - dwcg_pkg::SIDE_W'(s1_desc.y0) +
                   dwcg_pkg::SIDE_W'(1);
  assign product = x_span * y_span;

  always_comb begin
    push_desc      = s1_desc;
    push_desc.area = (s1_desc.kind == dwcg_pkg::JOB_WINDOW) ?
                     dwcg_pkg::AREA_W'(product) : '0;
  end

  assign push = s1_valid;

  a_reserved_space: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (queue_count != dwcg_pkg::QCOUNT_W'(dwcg_pkg::QUEUE_DEPTH)))
    else $error("job ready for the queue without reserved space");

endmodule

>>> design/dwcg_back.sv
// ----------------------------------------------------------------------------
// Word sequencer
// Takes jobs from the queue and emits their command, data and status words,
// one word per clock cycle.
// ----------------------------------------------------------------------------
module dwcg_back (
  input  logic                          clk,
  input  logic                          rst,
  input  dwcg_pkg::job_desc_t           head,
  input  logic [dwcg_pkg::QCOUNT_W-1:0] queue_count,
  output logic                          pop,
  output logic                          strobe,
  output logic [2:0]                    word_kind,
  output logic [dwcg_pkg::WORD_W-1:0]   word_value,
  output logic                          on_screen,
  output logic [dwcg_pkg::AREA_W-1:0]   clipped_area,
  output logic                          last_word
);

  logic [dwcg_pkg::STEP_W-1:0] step;
  logic [dwcg_pkg::STEP_W-1:0] last_step;
  logic                        have_job;
  logic                        at_last;
  logic [2:0]                  kind_next;
  logic [dwcg_pkg::WORD_W-1:0] value_next;

  assign have_job = queue_count != '0;

  always_comb begin
    case (head.kind)
      dwcg_pkg::JOB_STATUS: last_step = dwcg_pkg::STEP_W'(0);
      dwcg_pkg::JOB_ORIENT: last_step = dwcg_pkg::STEP_W'(2);
      dwcg_pkg::JOB_WINDOW: last_step = dwcg_pkg::STEP_W'(6);
      default:              last_step = dwcg_pkg::STEP_W'(7);
    endcase
  end

  assign at_last = step == last_step;
  assign pop     = have_job && at_last;

  always_comb begin
    kind_next  = dwcg_pkg::KIND_CMD;
    value_next = '0;
    case (head.kind)
      dwcg_pkg::JOB_STATUS: begin
        kind_next = dwcg_pkg::KIND_STATUS;
      end
      dwcg_pkg::JOB_ORIENT: begin
        case (step)
          dwcg_pkg::STEP_W'(0): value_next = dwcg_pkg::WORD_W'(dwcg_pkg::CMD_ACCESS);
          dwcg_pkg::STEP_W'(1): begin
            kind_next  = dwcg_pkg::KIND_BYTE;
            value_next = head.data;
          end
          default: value_next = dwcg_pkg::WORD_W'(dwcg_pkg::CMD_MEMWRITE);
        endcase
      end
      default: begin
        case (step)
          dwcg_pkg::STEP_W'(0): value_next = dwcg_pkg::WORD_W'(dwcg_pkg::CMD_COLUMN);
          dwcg_pkg::STEP_W'(1): begin
            kind_next  = dwcg_pkg::KIND_WORD;
            value_next = dwcg_pkg::WORD_W'(head.x0);
          end
          dwcg_pkg::STEP_W'(2): begin
            kind_next  = dwcg_pkg::KIND_WORD;
            value_next = dwcg_pkg::WORD_W'(head.x1);
          end
          dwcg_pkg::STEP_W'(3): value_next = dwcg_pkg::WORD_W'(dwcg_pkg::CMD_ROW);
          dwcg_pkg::STEP_W'(4): begin
            kind_next  = dwcg_pkg::KIND_WORD;
            value_next = dwcg_pkg::WORD_W'(head.y0);
          end
          dwcg_pkg::STEP_W'(5): begin
            kind_next  = dwcg_pkg::KIND_WORD;
            value_next = dwcg_pkg::WORD_W'(head.y1);
          end
          dwcg_pkg::STEP_W'(6): value_next = dwcg_pkg::WORD_W'(dwcg_pkg::CMD_MEMWRITE);
          default: begin
            if (head.kind == dwcg_pkg::JOB_READ) begin
              kind_next = dwcg_pkg::KIND_READ;
            end else begin
              kind_next  = dwcg_pkg::KIND_WORD;
              value_next = head.data;
            end
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= have_job;
      if (have_job) begin
        step <= at_last ? '0 : step + dwcg_pkg::STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (have_job) begin
      word_kind    <= kind_next;
      word_value   <= value_next;
      on_screen    <= head.kind != dwcg_pkg::JOB_STATUS;
      clipped_area <= head.area;
      last_word    <= at_last;
    end
  end

  a_pop_marks_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> (strobe && last_word))
    else $error("job retired without a final word");

  a_status_alone: assert property (@(posedge clk) disable iff (rst)
    (strobe && word_kind == dwcg_pkg::KIND_STATUS) |-> (last_word && !on_screen))
    else $error("status word not a lone rejection");

endmodule

>>> bench/display_window_command_generator_tb.sv
// ----------------------------------------------------------------------------
// Display window command generator testbench
// Feeds pixel, window and orientation requests under several panel settings
// and checks every emitted word against a behavioral prediction of the
// command stream, including bounds rejection and window clipping.
// ----------------------------------------------------------------------------
module display_window_command_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 250000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 15;

  // Row-mirror, column-mirror and swap bits for each orientation code.
  localparam bit [2:0] ORIENT_MAP [8] = '{3'b100, 3'b111, 3'b010, 3'b001,
                                         3'b110, 3'b101, 3'b000, 3'b011};

  typedef struct {
    logic [1:0]                          op;
    logic signed [dwcg_pkg::POS_W-1:0]   x;
    logic signed [dwcg_pkg::POS_W-1:0]   y;
    logic [dwcg_pkg::WORD_W-1:0]         w;
    logic [dwcg_pkg::WORD_W-1:0]         h;
    logic [dwcg_pkg::WORD_W-1:0]         color;
    int                                  gap;
    bit                                  drain_first;
  } panel_request_t;

  typedef struct {
    logic [2:0]                  kind;
    logic [dwcg_pkg::WORD_W-1:0] value;
    logic                        on;
    logic [dwcg_pkg::AREA_W-1:0] area;
    logic                        last;
  } panel_word_t;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] operation = dwcg_pkg::OP_WRITE_PIXEL;
  logic signed [dwcg_pkg::POS_W-1:0] pos_x = '0;
  logic signed [dwcg_pkg::POS_W-1:0] pos_y = '0;
  logic [dwcg_pkg::WORD_W-1:0] win_width = '0;
  logic [dwcg_pkg::WORD_W-1:0] win_height = '0;
  logic [dwcg_pkg::WORD_W-1:0] pixel_color = '0;
  logic cfg_write = 1'b0;
  logic [dwcg_pkg::CFG_INDEX_W-1:0] cfg_index = dwcg_pkg::REG_ORIENTATION;
  logic [dwcg_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic strobe;
  logic [2:0] word_kind;
  logic [dwcg_pkg::WORD_W-1:0] word_value;
  logic on_screen;
  logic [dwcg_pkg::AREA_W-1:0] clipped_area;
  logic last_word;

  // Testbench copy of the panel settings.
  logic [2:0] cfg_orientation = 3'd0;
  logic cfg_bgr = 1'b1;
  logic [dwcg_pkg::CFG_DATA_W-1:0] cfg_native_w = dwcg_pkg::CFG_DATA_W'(240);
  logic [dwcg_pkg::CFG_DATA_W-1:0] cfg_native_h = dwcg_pkg::CFG_DATA_W'(320);
  logic cfg_readback = 1'b1;

  panel_request_t pending_requests[$];
  panel_word_t expected_words[$];
  panel_request_t presented;
  int wait_count = 0;
  int error_count = 0;
  int cycle_count = 0;

  display_window_command_generator uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .pos_x(pos_x), .pos_y(pos_y),
    .win_width(win_width), .win_height(win_height), .pixel_color(pixel_color),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .strobe(strobe), .word_kind(word_kind), .word_value(word_value),
    .on_screen(on_screen), .clipped_area(clipped_area), .last_word(last_word)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int panel_side(input logic [dwcg_pkg::CFG_DATA_W-1:0] v);
    if (v == '0) begin
      return 1;
    end
    if (int'(v) > dwcg_pkg::MAX_SIDE) begin
      return dwcg_pkg::MAX_SIDE;
    end
    return int'(v);
  endfunction

  function automatic int clamp_to(input int v, input int hi);
    if (v < 0) begin
      return 0;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // Screen size after rotation: the swap bit exchanges width and height.
  function automatic void screen_dims(output int sw, output int sh);
    bit [2:0] b;
    b = ORIENT_MAP[cfg_orientation];
    sw = b[0] ? panel_side(cfg_native_h) : panel_side(cfg_native_w);
    sh = b[0] ? panel_side(cfg_native_w) : panel_side(cfg_native_h);
  endfunction

  function automatic void push_word(input logic [2:0] kind, input int value,
                                    input logic on,
                                    input logic [dwcg_pkg::AREA_W-1:0] area,
                                    input logic last);
    panel_word_t wd;
    wd.kind = kind;
    wd.value = dwcg_pkg::WORD_W'(value);
    wd.on = on;
    wd.area = area;
    wd.last = last;
    expected_words.push_back(wd);
  endfunction

  function automatic void push_ranges(input int x0, input int x1, input int y0,
                                      input int y1,
                                      input logic [dwcg_pkg::AREA_W-1:0] area,
                                      input logic last);
    push_word(dwcg_pkg::KIND_CMD, int'(dwcg_pkg::CMD_COLUMN), 1'b1, area, 1'b0);
    push_word(dwcg_pkg::KIND_WORD, x0, 1'b1, area, 1'b0);
    push_word(dwcg_pkg::KIND_WORD, x1, 1'b1, area, 1'b0);
    push_word(dwcg_pkg::KIND_CMD, int'(dwcg_pkg::CMD_ROW), 1'b1, area, 1'b0);
    push_word(dwcg_pkg::KIND_WORD, y0, 1'b1, area, 1'b0);
    push_word(dwcg_pkg::KIND_WORD, y1, 1'b1, area, 1'b0);
    push_word(dwcg_pkg::KIND_CMD, int'(dwcg_pkg::CMD_MEMWRITE), 1'b1, area, last);
  endfunction

  // Works out the word stream that one accepted request must produce.
  function automatic void predict_panel_words(input panel_request_t r);
    int sw, sh, x, y, x0, x1, y0, y1;
    bit [2:0] b;
    bit [31:0] area;
    bit visible;
    b = ORIENT_MAP[cfg_orientation];
    screen_dims(sw, sh);
    x = int'(r.x);
    y = int'(r.y);
    if (r.op == dwcg_pkg::OP_ORIENT) begin
      push_word(dwcg_pkg::KIND_CMD, int'(dwcg_pkg::CMD_ACCESS), 1'b1, '0, 1'b0);
      push_word(dwcg_pkg::KIND_BYTE,
                (int'(b[2]) << 7) | (int'(b[1]) << 6) | (int'(b[0]) << 5) |
                (int'(cfg_bgr) << 3), 1'b1, '0, 1'b0);
      push_word(dwcg_pkg::KIND_CMD, int'(dwcg_pkg::CMD_MEMWRITE), 1'b1, '0, 1'b1);
    end else if (r.op == dwcg_pkg::OP_SET_WINDOW) begin
      x1 = clamp_to(x + int'(r.w) - 1, sw - 1);
      x0 = clamp_to(x, sw - 1);
      y1 = clamp_to(y + int'(r.h) - 1, sh - 1);
      y0 = clamp_to(y, sh - 1);
      area = 32'(x1 - x0 + 1) * 32'(y1 - y0 + 1);
      push_ranges(x0, x1, y0, y1, area[dwcg_pkg::AREA_W-1:0], 1'b1);
    end else begin
      visible = x >= 0 && x < sw && y >= 0 && y < sh;
      if (r.op == dwcg_pkg::OP_READ_PIXEL && !cfg_readback) begin
        visible = 1'b0;
      end
      if (!visible) begin
        push_word(dwcg_pkg::KIND_STATUS, 0, 1'b0, '0, 1'b1);
      end else begin
        push_ranges(x, sw - 1, y, sh - 1, '0, 1'b0);
        if (r.op == dwcg_pkg::OP_WRITE_PIXEL) begin
          push_word(dwcg_pkg::KIND_WORD, int'(r.color), 1'b1, '0, 1'b1);
        end else begin
          push_word(dwcg_pkg::KIND_READ, 0, 1'b1, '0, 1'b1);
        end
      end
    end
  endfunction

  // Request driver: presents queued requests, honoring gaps and drain pauses.
  always @(posedge clk) begin
    panel_request_t nxt;
    bit accepted;
    bit go;
    accepted = start && !busy;
    go = 1'b0;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (accepted) begin
        predict_panel_words(presented);
      end
      if (!start || accepted) begin
        if (pending_requests.size() != 0) begin
          nxt = pending_requests[0];
          if (nxt.drain_first && expected_words.size() != 0) begin
            go = 1'b0;
          end else if (wait_count < nxt.gap) begin
            wait_count++;
          end else begin
            void'(pending_requests.pop_front());
            presented = nxt;
            wait_count = 0;
            go = 1'b1;
            operation <= nxt.op;
            pos_x <= nxt.x;
            pos_y <= nxt.y;
            win_width <= nxt.w;
            win_height <= nxt.h;
            pixel_color <= nxt.color;
          end
        end
        start <= go;
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      error_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $realtime, name, exp_v, act_v);
    end
  endfunction

  // Word monitor: every strobed word is one transaction and is checked at once.
  always @(posedge clk) begin
    panel_word_t exp_w;
    if (!rst && strobe) begin
      if (expected_words.size() == 0) begin
        error_count++;
        $display("%0t: unexpected word, expected none, actual kind %0d value 0x%0h",
                 $realtime, word_kind, word_value);
      end else begin
        exp_w = expected_words.pop_front();
        check_field("word_kind", exp_w.kind, word_kind);
        check_field("word_value", exp_w.value, word_value);
        check_field("on_screen", exp_w.on, on_screen);
        check_field("clipped_area", exp_w.area, clipped_area);
        check_field("last_word", exp_w.last, last_word);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_panel_reg(input logic [dwcg_pkg::CFG_INDEX_W-1:0] idx,
                                 input logic [dwcg_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      dwcg_pkg::REG_ORIENTATION:      cfg_orientation = val[2:0];
      dwcg_pkg::REG_COLOR_ORDER_BGR:  cfg_bgr = val[0];
      dwcg_pkg::REG_NATIVE_WIDTH:     cfg_native_w = val;
      dwcg_pkg::REG_NATIVE_HEIGHT:    cfg_native_h = val;
      dwcg_pkg::REG_READBACK_PRESENT: cfg_readback = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || start || expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void queue_request(input logic [1:0] op, input int x, input int y,
                                        input int w, input int h, input int color,
                                        input int gap, input bit drain_first);
    panel_request_t r;
    r.op = op;
    r.x = dwcg_pkg::POS_W'(x);
    r.y = dwcg_pkg::POS_W'(y);
    r.w = dwcg_pkg::WORD_W'(w);
    r.h = dwcg_pkg::WORD_W'(h);
    r.color = dwcg_pkg::WORD_W'(color);
    r.gap = gap;
    r.drain_first = drain_first;
    pending_requests.push_back(r);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_coord(input int side);
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return $urandom_range(0, side - 1);
    end else if (r < 80) begin
      case ($urandom_range(0, 3))
        0: return 0;
        1: return side - 1;
        2: return side;
        default: return -1;
      endcase
    end else if (r < 90) begin
      return int'($urandom_range(0, side + 8)) - 4;
    end
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int pick_extent(input int side);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return $urandom_range(0, side);
    end else if (r < 80) begin
      return $urandom_range(0, 16);
    end
    return $urandom_range(0, 65535);
  endfunction

  function automatic void queue_random_request(input bit burst);
    int sw, sh, r;
    logic [1:0] op;
    screen_dims(sw, sh);
    r = $urandom_range(0, 99);
    if (r < 30) begin
      op = dwcg_pkg::OP_WRITE_PIXEL;
    end else if (r < 55) begin
      op = dwcg_pkg::OP_READ_PIXEL;
    end else if (r < 85) begin
      op = dwcg_pkg::OP_SET_WINDOW;
    end else begin
      op = dwcg_pkg::OP_ORIENT;
    end
    queue_request(op, pick_coord(sw), pick_coord(sh), pick_extent(sw), pick_extent(sh),
                  $urandom_range(0, 65535), burst ? 0 : pick_gap(),
                  $urandom_range(0, 99) < 4);
  endfunction

  function automatic int pick_side_setting(input int phase);
    case (phase)
      1: return 1;
      2: return dwcg_pkg::MAX_SIDE;
      3: return 0;
      4: return (1 << dwcg_pkg::CFG_DATA_W) - 1;
      5: return dwcg_pkg::MAX_SIDE + 1;
      default: return $urandom_range(1, dwcg_pkg::MAX_SIDE);
    endcase
  endfunction

  initial begin
    int sw, sh;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed requests under the reset settings, sent back to back.
    screen_dims(sw, sh);
    queue_request(dwcg_pkg::OP_ORIENT, 0, 0, 0, 0, 0, 0, 1'b0);
    queue_request(dwcg_pkg::OP_WRITE_PIXEL, 0, 0, 0, 0, 16'h0000, 0, 1'b0);
    queue_request(dwcg_pkg::OP_WRITE_PIXEL, sw - 1, sh - 1, 65535, 65535, 16'hFFFF, 0,
                  1'b0);
    queue_request(dwcg_pkg::OP_WRITE_PIXEL, sw, 0, 0, 0, 16'h1234, 0, 1'b0);
    queue_request(dwcg_pkg::OP_WRITE_PIXEL, 0, sh, 0, 0, 16'h5678, 0, 1'b0);
    queue_request(dwcg_pkg::OP_WRITE_PIXEL, -1, 5, 0, 0, 16'h0F0F, 0, 1'b0);
    queue_request(dwcg_pkg::OP_WRITE_PIXEL, -32768, 32767, 0, 0, 16'hF0F0, 0, 1'b0);
    queue_request(dwcg_pkg::OP_WRITE_PIXEL, 32767, -32768, 0, 0, 16'h8001, 0, 1'b0);
    queue_request(dwcg_pkg::OP_READ_PIXEL, 10, 20, 0, 0, 0, 0, 1'b0);
    queue_request(dwcg_pkg::OP_READ_PIXEL, sw - 1, sh - 1, 0, 0, 0, 0, 1'b0);
    queue_request(dwcg_pkg::OP_READ_PIXEL, -5, 0, 0, 0, 0, 0, 1'b0);
    queue_request(dwcg_pkg::OP_SET_WINDOW, 0, 0, sw, sh, 0, 0, 1'b0);
    queue_request(dwcg_pkg::OP_SET_WINDOW, 10, 10, 0, 5, 0, 0, 1'b0);
    queue_request(dwcg_pkg::OP_SET_WINDOW, 10, 10, 5, 0, 0, 0, 1'b0);
    queue_request(dwcg_pkg::OP_SET_WINDOW, 0, 0, 0, 0, 0, 0, 1'b0);
    queue_request(dwcg_pkg::OP_SET_WINDOW, -100, -100, 50, 50, 0, 0, 1'b0);
    queue_request(dwcg_pkg::OP_SET_WINDOW, 500, 600, 10, 10, 0, 0, 1'b0);
    queue_request(dwcg_pkg::OP_SET_WINDOW, -32768, -32768, 65535, 65535, 0, 0, 1'b0);
    queue_request(dwcg_pkg::OP_SET_WINDOW, 32767, 32767, 65535, 65535, 0, 0, 1'b0);
    queue_request(dwcg_pkg::OP_SET_WINDOW, 5, -3, 20, 7, 0, 0, 1'b0);
    // This one waits for the stream to drain before it is presented.
    queue_request(dwcg_pkg::OP_WRITE_PIXEL, 5, 5, 0, 0, 16'hA5A5, 0, 1'b1);
    queue_request(dwcg_pkg::OP_ORIENT, -1, -1, 65535, 65535, 16'hFFFF, 0, 1'b0);
    wait_idle();

    for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
      write_panel_reg(dwcg_pkg::REG_ORIENTATION,
                      dwcg_pkg::CFG_DATA_W'((phase - 1) % 8));
      write_panel_reg(dwcg_pkg::REG_COLOR_ORDER_BGR, dwcg_pkg::CFG_DATA_W'(phase % 2));
      write_panel_reg(dwcg_pkg::REG_NATIVE_WIDTH,
                      dwcg_pkg::CFG_DATA_W'(pick_side_setting(phase)));
      write_panel_reg(dwcg_pkg::REG_NATIVE_HEIGHT,
                      dwcg_pkg::CFG_DATA_W'(pick_side_setting((phase + 2) % 6)));
      write_panel_reg(dwcg_pkg::REG_READBACK_PRESENT,
                      dwcg_pkg::CFG_DATA_W'(phase % 3 != 1));
      @(posedge clk);
      cfg_write <= 1'b0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        queue_random_request(phase % 3 == 0);
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/dwcg_pkg.sv
design/dwcg_queue.sv
design/dwcg_front.sv
design/dwcg_back.sv
design/display_window_command_generator.sv
bench/display_window_command_generator_tb.sv
